// ----- rtl/core/keyed_mean_with_missing_table_defines.svh -----
// Assertion macros for the keyed mean table.
`ifndef KEYED_MEAN_WITH_MISSING_TABLE_DEFINES_SVH
`define KEYED_MEAN_WITH_MISSING_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define KMT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KMT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KMT_ASSERT(lbl, clk, rst_n, prop, msg)
`define KMT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/kmt_pkg.sv -----
// Shared types and codes for the keyed mean table.
`default_nettype none
package kmt_pkg;
  localparam logic [1:0] CMD_ACC    = 2'd0;
  localparam logic [1:0] CMD_FINAL  = 2'd1;
  localparam logic [1:0] CMD_LK_KEY = 2'd2;
  localparam logic [1:0] CMD_LK_IDX = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOTFND  = 2'd2;
  localparam logic [1:0] ST_ALLMISS = 2'd3;

  localparam int SUM_W = 56;
  localparam int ENTRY_W = 64 + SUM_W + 32 + 32;

  typedef struct packed {
    logic [63:0]      key;
    logic [SUM_W-1:0] sum;
    logic [31:0]      cnt;
    logic [31:0]      miss;
  } entry_t;
endpackage
`default_nettype wire

// ----- rtl/core/keyed_mean_with_missing_table.sv -----
// Keyed mean table: top level with sequencer, table RAM and serial divider.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+---------------------------
//  in      | in_cmd in_key_hash in_sample_value ... | start & !busy
//  out     | out_status out_found_index ...         | out_strobe, one cycle
//  cfg     | cfg_data                               | cfg_valid & cfg_ready
//
// Every scan reads the table one entry per cycle from RAM (registered read).
// Per command:
//   accumulate: key scan; update on a hit, else append (ST_FULL if full).
//   finalize: all-missing check scan (reports the first hit), then a pass
//     over all entries to fold in implicit zeros the first time.
//   lookup: by key a scan, by index a direct read (not found if out of range);
//     a nonzero count runs the 56-bit restoring divider for the mean.
// Strobe comes in the first idle cycle; no clearing pass after reset.
// The receiver cannot stall; config is taken only while idle and no start.
`default_nettype none
`include "keyed_mean_with_missing_table_defines.svh"
module keyed_mean_with_missing_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [63:0] in_key_hash,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic        in_value_missing,
  input  wire logic [7:0]  in_entry_index,
  output logic             out_strobe,
  output logic [1:0]       out_status,
  output logic [7:0]       out_found_index,
  output logic [63:0]      out_found_key,
  output logic [31:0]      out_present_count,
  output logic [31:0]      out_missing_count,
  output logic signed [31:0] out_mean_value,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int SW = kmt_pkg::SUM_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SCHK = 4'd2,
                         S_UPD  = 4'd3, S_F2   = 4'd4, S_F2W  = 4'd5,
                         S_DIV  = 4'd6, S_OUT  = 4'd7, S_RD   = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] cmd_r;
  logic [63:0] key_r;
  logic signed [31:0] val_r;
  logic miss_r;
  logic [7:0] idx_r;
  logic [CW-1:0] used_r, used_nxt;
  logic fin_r, fin_nxt;
  logic [31:0] total_r;
  logic [CW-1:0] ptr_r, ptr_nxt;   // address issued
  logic [AW-1:0] hit_r, hit_nxt;   // entry under work
  logic rd_pend_r, rd_pend_nxt;    // read data valid next cycle
  kmt_pkg::entry_t ent_r, ent_nxt;

  // divider
  logic [SW-1:0] dq_r, dq_nxt;     // magnitude -> quotient
  logic [SW:0]   drem_r, drem_nxt;
  logic [5:0]    dcnt_r, dcnt_nxt;
  logic          dneg_r, dneg_nxt;

  // result
  logic          ostb_r, ostb_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [7:0]    oidx_r, oidx_nxt;
  logic [63:0]   okey_r, okey_nxt;
  logic [31:0]   ocnt_r, ocnt_nxt, omis_r, omis_nxt, omean_r, omean_nxt;

  // RAM
  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  kmt_pkg::entry_t ram_wd, ram_rd;

  kmt_ram #(.WIDTH(kmt_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(ram_rd)
  );

  assign busy = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;
  assign out_strobe = ostb_r;
  assign out_status = ost_r;
  assign out_found_index = oidx_r;
  assign out_found_key = okey_r;
  assign out_present_count = ocnt_r;
  assign out_missing_count = omis_r;
  assign out_mean_value = omean_r;

  // updated entry for accumulate
  kmt_pkg::entry_t upd;
  logic signed [SW:0] sum_x;
  always_comb begin
    upd = ent_r;
    sum_x = {ent_r.sum[SW-1], ent_r.sum} + (SW+1)'(val_r);
    if (miss_r) begin
      if (ent_r.miss != 32'hFFFF_FFFF) upd.miss = ent_r.miss + 32'd1;
    end else begin
      if (ent_r.cnt != 32'hFFFF_FFFF) upd.cnt = ent_r.cnt + 32'd1;
      if (sum_x[SW] != sum_x[SW-1]) begin
        upd.sum = sum_x[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
        upd.sum = sum_x[SW-1:0];
      end
    end
  end

  logic [SW:0]   rtrial;
  logic [SW:0]   rshift;
  always_comb begin
    rshift = {drem_r[SW-1:0], dq_r[SW-1]};
    rtrial = rshift - (SW+1)'(ent_r.cnt);
  end

  // final mean: saturate quotient, apply sign
  logic [31:0] mean_fin;
  always_comb begin
    if (dq_r > SW'(32'h7FFF_FFFF) + SW'(dneg_r)) begin
      mean_fin = dneg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      mean_fin = dneg_r ? (~dq_r[31:0] + 32'd1) : dq_r[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt = used_r;
    fin_nxt = fin_r;
    ptr_nxt = ptr_r;
    hit_nxt = hit_r;
    rd_pend_nxt = 1'b0;
    ent_nxt = ent_r;
    dq_nxt = dq_r; drem_nxt = drem_r; dcnt_nxt = dcnt_r; dneg_nxt = dneg_r;
    ostb_nxt = 1'b0;
    ost_nxt = ost_r; oidx_nxt = oidx_r; okey_nxt = okey_r;
    ocnt_nxt = ocnt_r; omis_nxt = omis_r; omean_nxt = omean_r;
    ram_we = 1'b0;
    ram_wa = hit_r;
    ram_wd = upd;
    ram_ra = ptr_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          ptr_nxt = '0;
          if (in_cmd == kmt_pkg::CMD_LK_IDX) begin
            state_nxt = S_RD;
            ptr_nxt = CW'(in_entry_index);
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_RD: begin
        // check index; read issued from ptr this cycle
        if (ptr_r >= used_r || 32'(ptr_r) != 32'(idx_r)) begin
          ost_nxt = kmt_pkg::ST_NOTFND; oidx_nxt = '0; okey_nxt = '0;
          ocnt_nxt = '0; omis_nxt = '0; omean_nxt = '0;
          ostb_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          hit_nxt = ptr_r[AW-1:0];
          rd_pend_nxt = 1'b1;
          state_nxt = S_SCHK;
        end
      end
      S_SCAN: begin
        // issue reads for 0..used-1, check each returning datum
        if (rd_pend_r) begin
          if ((cmd_r == kmt_pkg::CMD_FINAL && ram_rd.miss == total_r) ||
              (cmd_r != kmt_pkg::CMD_FINAL && ram_rd.key == key_r)) begin
            ent_nxt = ram_rd;
            state_nxt = S_SCHK;
          end
        end
        if (state_nxt == S_SCAN) begin
          if (ptr_r < used_r) begin
            rd_pend_nxt = 1'b1;
            ptr_nxt = ptr_r + CW'(1);
            hit_nxt = ptr_r[AW-1:0];
          end else if (!rd_pend_r) begin
            // nothing matched
            ost_nxt = kmt_pkg::ST_OK; oidx_nxt = '0; okey_nxt = '0;
            ocnt_nxt = '0; omis_nxt = '0; omean_nxt = '0;
            state_nxt = S_IDLE; ostb_nxt = 1'b1;
            case (cmd_r)
              kmt_pkg::CMD_ACC: begin
                if (used_r >= DEPTH_C) begin
                  ost_nxt = kmt_pkg::ST_FULL;
                end else begin
                  ram_we = 1'b1;
                  ram_wa = used_r[AW-1:0];
                  ram_wd.key = key_r;
                  ram_wd.cnt = miss_r ? 32'd0 : 32'd1;
                  ram_wd.miss = miss_r ? 32'd1 : 32'd0;
                  ram_wd.sum = miss_r ? '0 : SW'(val_r);
                  used_nxt = used_r + CW'(1);
                  oidx_nxt = 8'(used_r);
                  okey_nxt = key_r;
                  ocnt_nxt = ram_wd.cnt;
                  omis_nxt = ram_wd.miss;
                end
              end
              kmt_pkg::CMD_FINAL: begin
                if (!fin_r) begin
                  ostb_nxt = 1'b0;
                  ptr_nxt = '0;
                  state_nxt = S_F2;
                end
              end
              default: begin
                ost_nxt = kmt_pkg::ST_NOTFND;
              end
            endcase
          end
        end
      end
      S_SCHK: begin
        // entry found (ent_r) or index read (data arriving now for index lookup)
        if (cmd_r == kmt_pkg::CMD_LK_IDX && rd_pend_r) begin
          ent_nxt = ram_rd;
          state_nxt = S_SCHK;
        end else begin
          ost_nxt = kmt_pkg::ST_OK;
          oidx_nxt = 8'(hit_r);
          okey_nxt = ent_r.key;
          ocnt_nxt = ent_r.cnt;
          omis_nxt = ent_r.miss;
          omean_nxt = '0;
          case (cmd_r)
            kmt_pkg::CMD_ACC: state_nxt = S_UPD;
            kmt_pkg::CMD_FINAL: begin
              ost_nxt = kmt_pkg::ST_ALLMISS;
              ostb_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
            default: begin
              if (ent_r.cnt == 32'd0) begin
                ostb_nxt = 1'b1;
                state_nxt = S_IDLE;
              end else begin
                dneg_nxt = ent_r.sum[SW-1];
                dq_nxt = ent_r.sum[SW-1] ? (~ent_r.sum + SW'(1)) : ent_r.sum;
                drem_nxt = '0;
                dcnt_nxt = 6'(SW);
                state_nxt = S_DIV;
              end
            end
          endcase
        end
      end
      S_UPD: begin
        ram_we = 1'b1;
        ocnt_nxt = upd.cnt;
        omis_nxt = upd.miss;
        ostb_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        if (rtrial[SW]) begin
          drem_nxt = rshift;
          dq_nxt = {dq_r[SW-2:0], 1'b0};
        end else begin
          drem_nxt = rtrial;
          dq_nxt = {dq_r[SW-2:0], 1'b1};
        end
        dcnt_nxt = dcnt_r - 6'd1;
        if (dcnt_r == 6'd1) state_nxt = S_OUT;
      end
      S_OUT: begin
        omean_nxt = mean_fin;
        ostb_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_F2: begin
        // read entry ptr
        if (ptr_r < used_r) begin
          hit_nxt = ptr_r[AW-1:0];
          ptr_nxt = ptr_r + CW'(1);
          state_nxt = S_F2W;
        end else begin
          fin_nxt = 1'b1;
          ost_nxt = kmt_pkg::ST_OK; oidx_nxt = '0; okey_nxt = '0;
          ocnt_nxt = '0; omis_nxt = '0; omean_nxt = '0;
          ostb_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_F2W: begin
        ram_wd = ram_rd;
        if (ram_rd.miss < total_r && (total_r - ram_rd.miss) > ram_rd.cnt) begin
          ram_wd.cnt = total_r - ram_rd.miss;
        end
        ram_we = 1'b1;
        state_nxt = S_F2;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      fin_r <= 1'b0;
      total_r <= '0;
      ostb_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r <= used_nxt;
      fin_r <= fin_nxt;
      ostb_r <= ostb_nxt;
      rd_pend_r <= rd_pend_nxt;
      if (cfg_valid && cfg_ready) total_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_cmd;
      key_r <= in_key_hash;
      val_r <= in_sample_value;
      miss_r <= in_value_missing;
      idx_r <= in_entry_index;
    end
    ptr_r <= ptr_nxt;
    hit_r <= hit_nxt;
    ent_r <= ent_nxt;
    dq_r <= dq_nxt; drem_r <= drem_nxt; dcnt_r <= dcnt_nxt; dneg_r <= dneg_nxt;
    ost_r <= ost_nxt; oidx_r <= oidx_nxt; okey_r <= okey_nxt;
    ocnt_r <= ocnt_nxt; omis_r <= omis_nxt; omean_r <= omean_nxt;
  end

  `KMT_ASSERT(a_used_bound, clk, rst_n, used_r <= DEPTH_C, "entries_used past depth")
  `KMT_ASSERT(a_strobe_idle, clk, rst_n, out_strobe |-> !busy, "strobe while busy")
  `KMT_ASSERT(a_fin_sticky, clk, rst_n, $past(fin_r) |-> fin_r, "finalized flag cleared")
  `KMT_ASSERT_RST(a_rst_idle, clk, !rst_n |=> !busy, "busy after reset")
endmodule
`default_nettype wire

// ----- rtl/core/kmt_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
`default_nettype none
module kmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- dv/keyed_mean_with_missing_table_tb.sv -----
// Self-checking testbench for the keyed mean table: directed rows, then random phases.
`timescale 1ns / 1ps
`default_nettype none
module keyed_mean_with_missing_table_tb;

  localparam int DEPTH = 256;
  localparam longint SUM_HI = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int KEY_POOL_N = 40;

  // One result beat, field by field.
  typedef struct {
    logic [1:0]  st;
    logic [7:0]  idx;
    logic [63:0] key;
    logic [31:0] pcnt;
    logic [31:0] mcnt;
    logic [31:0] mean;
  } mean_res_t;

  // One directed stimulus row; typed rows carry their answer inline.
  typedef struct {
    logic [1:0]  cmd;
    logic [63:0] key;
    logic [31:0] val;
    bit          miss;
    logic [7:0]  eidx;
    bit          typed;
    mean_res_t   want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = kmt_pkg::CMD_ACC;
  logic [63:0] in_key_hash = '0;
  logic signed [31:0] in_sample_value = '0;
  logic        in_value_missing = 1'b0;
  logic [7:0]  in_entry_index = '0;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [7:0]  out_found_index;
  logic [63:0] out_found_key;
  logic [31:0] out_present_count;
  logic [31:0] out_missing_count;
  logic signed [31:0] out_mean_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  keyed_mean_with_missing_table #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_key_hash(in_key_hash), .in_sample_value(in_sample_value),
    .in_value_missing(in_value_missing), .in_entry_index(in_entry_index),
    .out_strobe(out_strobe), .out_status(out_status), .out_found_index(out_found_index),
    .out_found_key(out_found_key), .out_present_count(out_present_count),
    .out_missing_count(out_missing_count), .out_mean_value(out_mean_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the table: keys, saturated sums, counts, and the global flags.
  logic [63:0] shadow_key [DEPTH];
  longint      shadow_sum [DEPTH];
  logic [31:0] shadow_cnt [DEPTH];
  logic [31:0] shadow_miss [DEPTH];
  int          shadow_used = 0;
  bit          shadow_final = 1'b0;
  logic [31:0] shadow_total = '0;

  mean_res_t   pending_means[$];
  int          err_cnt = 0;
  int          cyc_cnt = 0;
  int          idle_pct = 0;
  logic [63:0] key_pool [KEY_POOL_N];
  stim_row_t   dir_rows[$];

  // Entry snapshot; mean only on lookups. Mean truncates toward zero.
  function automatic mean_res_t entry_view(int i, bit with_mean, logic [1:0] st);
    mean_res_t r;
    longint m;
    r.st = st;
    r.idx = i[7:0];
    r.key = shadow_key[i];
    r.pcnt = shadow_cnt[i];
    r.mcnt = shadow_miss[i];
    r.mean = '0;
    if (with_mean && shadow_cnt[i] != 0) begin
      m = shadow_sum[i] / longint'({32'b0, shadow_cnt[i]});
      if (m > 64'sd2147483647) m = 64'sd2147483647;
      if (m < -64'sd2147483648) m = -64'sd2147483648;
      r.mean = m[31:0];
    end
    return r;
  endfunction

  // Applies one command to the shadow table and returns the expected beat.
  function automatic mean_res_t table_step(logic [1:0] cmd, logic [63:0] key,
                                           logic [31:0] val, bit miss, logic [7:0] eidx);
    mean_res_t r;
    int hit;
    longint s;
    logic [31:0] tgt;
    r = '{st: kmt_pkg::ST_OK, idx: '0, key: '0, pcnt: '0, mcnt: '0, mean: '0};
    hit = -1;
    for (int i = 0; i < shadow_used; i++) begin
      if (shadow_key[i] == key) begin
        hit = i;
        break;
      end
    end
    case (cmd)
      kmt_pkg::CMD_ACC: begin
        if (hit >= 0) begin
          if (miss) begin
            if (shadow_miss[hit] != 32'hFFFF_FFFF) shadow_miss[hit]++;
          end else begin
            if (shadow_cnt[hit] != 32'hFFFF_FFFF) shadow_cnt[hit]++;
            s = shadow_sum[hit] + longint'(signed'(val));
            if (s > SUM_HI) s = SUM_HI;
            if (s < SUM_LO) s = SUM_LO;
            shadow_sum[hit] = s;
          end
        end else if (shadow_used >= DEPTH) begin
          r.st = kmt_pkg::ST_FULL;
          return r;
        end else begin
          hit = shadow_used;
          shadow_key[hit] = key;
          shadow_cnt[hit] = miss ? 32'd0 : 32'd1;
          shadow_sum[hit] = miss ? 64'sd0 : longint'(signed'(val));
          shadow_miss[hit] = miss ? 32'd1 : 32'd0;
          shadow_used++;
        end
        r = entry_view(hit, 1'b0, kmt_pkg::ST_OK);
      end
      kmt_pkg::CMD_FINAL: begin
        // all-missing check first, lowest entry wins, nothing changes
        for (int i = 0; i < shadow_used; i++) begin
          if (shadow_miss[i] == shadow_total)
            return entry_view(i, 1'b0, kmt_pkg::ST_ALLMISS);
        end
        // implicit zeros are folded in only once
        if (!shadow_final) begin
          for (int i = 0; i < shadow_used; i++) begin
            if (shadow_miss[i] < shadow_total) begin
              tgt = shadow_total - shadow_miss[i];
              if (tgt > shadow_cnt[i]) shadow_cnt[i] = tgt;
            end
          end
          shadow_final = 1'b1;
        end
      end
      kmt_pkg::CMD_LK_KEY: begin
        if (hit >= 0) r = entry_view(hit, 1'b1, kmt_pkg::ST_OK);
        else r.st = kmt_pkg::ST_NOTFND;
      end
      default: begin
        if (int'(eidx) < shadow_used) r = entry_view(int'(eidx), 1'b1, kmt_pkg::ST_OK);
        else r.st = kmt_pkg::ST_NOTFND;
      end
    endcase
    return r;
  endfunction

  // Drives one command beat from a falling edge and holds it until accepted.
  task automatic send_cmd(logic [1:0] cmd, logic [63:0] key, logic [31:0] val, bit miss,
                          logic [7:0] eidx, bit typed, mean_res_t want);
    mean_res_t got;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    in_cmd = cmd;
    in_key_hash = key;
    in_sample_value = val;
    in_value_missing = miss;
    in_entry_index = eidx;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    got = table_step(cmd, key, val, miss, eidx);
    pending_means = {pending_means, (typed ? want : got)};
    @(negedge clk);
    start = 1'b0;
  endtask

  // Waits for the table to drain, then writes example_total.
  task automatic write_total(logic [31:0] v);
    while (pending_means.size() != 0 || busy) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    shadow_total = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_row(logic [1:0] cmd, logic [63:0] key, logic [31:0] val, bit miss,
                         logic [7:0] eidx, bit typed, logic [1:0] st);
    stim_row_t r;
    r.cmd = cmd;
    r.key = key;
    r.val = val;
    r.miss = miss;
    r.eidx = eidx;
    r.typed = typed;
    r.want = '{st: st, idx: '0, key: '0, pcnt: '0, mcnt: '0, mean: '0};
    dir_rows = {dir_rows, r};
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Value mix: mostly random, sometimes the Q16.16 extremes or small numbers.
  function automatic logic [31:0] rand_val();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(8) - 4;
      default: return $urandom;
    endcase
  endfunction

  // One random command; fill mode mostly brings in fresh keys.
  task automatic send_random(bit fill);
    logic [1:0] cmd;
    logic [63:0] key;
    logic [7:0] eidx;
    int pick;
    mean_res_t none;
    none = '{st: kmt_pkg::ST_OK, idx: '0, key: '0, pcnt: '0, mcnt: '0, mean: '0};
    pick = $urandom_range(99);
    if (pick < 60) cmd = kmt_pkg::CMD_ACC;
    else if (pick < 65) cmd = kmt_pkg::CMD_FINAL;
    else if (pick < 82) cmd = kmt_pkg::CMD_LK_KEY;
    else cmd = kmt_pkg::CMD_LK_IDX;
    if (fill ? ($urandom_range(99) < 95) : ($urandom_range(99) < 12)) key = rand_key();
    else if (cmd == kmt_pkg::CMD_LK_KEY && shadow_used > 0 && $urandom_range(99) < 80)
      key = shadow_key[$urandom_range(shadow_used - 1)];
    else key = key_pool[$urandom_range(KEY_POOL_N - 1)];
    if (shadow_used > 0 && $urandom_range(99) < 70) eidx = 8'($urandom_range(shadow_used - 1));
    else eidx = 8'($urandom_range(255));
    send_cmd(cmd, key, rand_val(), $urandom_range(3) == 0, eidx, 1'b0, none);
  endtask

  // Result checker: every strobe beat against the oldest expectation.
  always @(posedge clk) begin
    mean_res_t e;
    if (rst_n && out_strobe) begin
      if (pending_means.size() == 0) begin
        $display("%0t: unexpected result beat, status %0d", $time, out_status);
        err_cnt++;
      end else begin
        e = pending_means.pop_front();
        if (out_status !== e.st) begin
          $display("%0t: status exp %0d got %0d", $time, e.st, out_status);
          err_cnt++;
        end
        if (out_found_index !== e.idx) begin
          $display("%0t: index exp %0d got %0d", $time, e.idx, out_found_index);
          err_cnt++;
        end
        if (out_found_key !== e.key) begin
          $display("%0t: key exp %h got %h", $time, e.key, out_found_key);
          err_cnt++;
        end
        if (out_present_count !== e.pcnt) begin
          $display("%0t: present exp %0d got %0d", $time, e.pcnt, out_present_count);
          err_cnt++;
        end
        if (out_missing_count !== e.mcnt) begin
          $display("%0t: missing exp %0d got %0d", $time, e.mcnt, out_missing_count);
          err_cnt++;
        end
        if (out_mean_value !== e.mean) begin
          $display("%0t: mean exp %h got %h", $time, e.mean, out_mean_value);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] totals [6];
    int burst;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = rand_key();

    // empty table: lookups miss
    add_row(kmt_pkg::CMD_LK_IDX, '0, '0, 1'b0, 8'd0, 1'b1, kmt_pkg::ST_NOTFND);
    add_row(kmt_pkg::CMD_LK_KEY, '0, '0, 1'b0, 8'd0, 1'b1, kmt_pkg::ST_NOTFND);
    // key and value extremes, missing marks
    add_row(kmt_pkg::CMD_ACC, '0, 32'h7FFF_FFFF, 1'b0, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_ACC, '1, 32'h8000_0000, 1'b0, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_ACC, '0, '0, 1'b1, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_ACC, '0, 32'hFFFF_FFFF, 1'b0, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_ACC, '1, 32'h7FFF_FFFF, 1'b0, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_ACC, 64'h5555_5555_5555_5555, 32'h0001_0000, 1'b1, 8'd0, 1'b0,
            kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_ACC, '1, 32'h8000_0000, 1'b0, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_LK_KEY, '0, '0, 1'b0, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_LK_KEY, '1, '0, 1'b0, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_LK_KEY, 64'h5555_5555_5555_5555, '0, 1'b0, 8'd0, 1'b0,
            kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_LK_KEY, 64'hAAAA_AAAA_AAAA_AAAA, '0, 1'b0, 8'd0, 1'b1,
            kmt_pkg::ST_NOTFND);
    add_row(kmt_pkg::CMD_LK_IDX, '0, '0, 1'b0, 8'd2, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_LK_IDX, '0, '0, 1'b0, 8'd3, 1'b1, kmt_pkg::ST_NOTFND);
    add_row(kmt_pkg::CMD_LK_IDX, '0, '0, 1'b0, 8'd255, 1'b1, kmt_pkg::ST_NOTFND);
    // example_total still 0: entries with no missing trip the all-missing check
    add_row(kmt_pkg::CMD_FINAL, '0, '0, 1'b0, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_ACC, 64'h5555_5555_5555_5555, '0, 1'b1, 8'd0, 1'b0, kmt_pkg::ST_OK);
    add_row(kmt_pkg::CMD_LK_IDX, '0, '0, 1'b0, 8'd0, 1'b0, kmt_pkg::ST_OK);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].val, dir_rows[i].miss,
               dir_rows[i].eidx, dir_rows[i].typed, dir_rows[i].want);

    // Phases: example_total setting, then idle mode cycles through
    // none / sender 70% / stall-equivalent 70% / both 38%.
    totals[0] = 32'd1;
    totals[1] = 32'hFFFF_FFFF;
    totals[2] = 32'd0;
    totals[3] = $urandom_range(20);
    totals[4] = 32'd2;
    totals[5] = $urandom;
    for (int ph = 0; ph < 6; ph++) begin
      write_total(totals[ph]);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 70;
        2: idle_pct = 70;
        default: idle_pct = 38;
      endcase
      // last phase fills the table and keeps hitting the full condition
      for (int n = 0; n < ((ph == 5) ? 300 : 150); n++) begin
        if (n % 50 == 25) begin
          burst = idle_pct;
          idle_pct = 0;
          repeat (10) send_random(ph == 5);
          idle_pct = burst;
        end else begin
          send_random(ph == 5);
        end
      end
    end

    while (pending_means.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl/core
rtl/core/kmt_pkg.sv
rtl/core/kmt_ram.sv
rtl/core/keyed_mean_with_missing_table.sv
dv/keyed_mean_with_missing_table_tb.sv
